// File: hw/rtl/bts_pkg.sv
package bts_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 20;
  localparam int unsigned NumSlots = 3;
  localparam int unsigned CfgIdxW  = 3;

  // Longest arm cycle or slot period that a start will accept, in microseconds.
  localparam logic [CfgW-1:0] MaxPeriodUs = 20'd1000000;

  typedef enum logic {
    OpPoll  = 1'b0,
    OpStart = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegArmPeriod    = 3'd0,
    RegArmWindow    = 3'd1,
    RegGuardTime    = 3'd2,
    RegMaxGap       = 3'd3,
    RegWheelPeriod  = 3'd4,
    RegLiftPeriod   = 3'd5,
    RegStatusPeriod = 3'd6
  } reg_idx_e;

  // Timing registers; slot_period[0] is the wheel slot, [1] lift, [2] status.
  typedef struct packed {
    logic [CfgW-1:0]                 arm_period;
    logic [CfgW-1:0]                 arm_window;
    logic [CfgW-1:0]                 guard_time;
    logic [CfgW-1:0]                 max_gap;
    logic [NumSlots-1:0][CfgW-1:0]   slot_period;
  } cfg_t;

  // Register file status handed to the scheduling engine.
  typedef struct packed {
    cfg_t regs;
    logic cfg_ok;
    logic disarm;
  } cfg_stat_t;

  typedef struct packed {
    op_e              opcode;
    logic [TimeW-1:0] time_us;
  } item_t;

  typedef struct packed {
    logic [CfgW-1:0]     free_time;
    logic [NumSlots-1:0] due_mask;
    logic                in_arm_window;
    logic                stop_needed;
    logic                start_accepted;
  } res_t;

endpackage

// File: hw/rtl/bts_if.sv
// Input channel: one scheduler command item.
interface bts_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] time_us;

  modport source (output valid, output opcode, output time_us, input ready);
  modport sink (input valid, input opcode, input time_us, output ready);
endinterface

// Output channel: one scheduling result item.
interface bts_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] free_time;
  logic [2:0]  due_mask;
  logic        in_arm_window;
  logic        stop_needed;
  logic        start_accepted;

  modport source (output valid, output free_time, output due_mask, output in_arm_window,
                  output stop_needed, output start_accepted, input ready);
  modport sink (input valid, input free_time, input due_mask, input in_arm_window,
                input stop_needed, input start_accepted, output ready);
endinterface

// File: hw/rtl/bus_time_slot_scheduler.sv
// Bus time slot scheduler. Each input item is a start or a poll stamped with a
// free-running 32-bit microsecond time, and each one produces exactly one result
// item. The block takes one item per clock cycle while the output is not stalled.
// Its path is an input register, combinational scheduling logic (elapsed-time
// subtract, phase wrap, three slot countdowns and the window compares) and a
// result register. State is updated as an item leaves the input register, so
// back-to-back polls see each other's effect. Input ready follows output ready
// combinationally when both registers are full. Timing registers are written
// through the write port only while the block is idle; the user must keep to
// this, the block itself does not enforce it. Any write to an existing register
// disarms the scheduler until the next successful start.
module bus_time_slot_scheduler
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  bts_in_if.sink             in_i,
  bts_out_if.source          out_o
);

  cfg_stat_t cfg_stat;
  item_t     in_item;
  item_t     stage_item;
  logic      stage_vld;
  logic      adv;
  res_t      res;

  assign in_item.opcode  = op_e'(in_i.opcode);
  assign in_item.time_us = in_i.time_us;

  // Timing register file and start validation.
  bts_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_o     (cfg_stat)
  );

  // Input register.
  bts_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .adv_i      (adv),
    .vld_o      (stage_vld),
    .item_o     (stage_item)
  );

  // Scheduling state, logic and result register.
  bts_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_stat),
    .vld_i       (stage_vld),
    .item_i      (stage_item),
    .adv_o       (adv),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.free_time      = res.free_time;
  assign out_o.due_mask       = res.due_mask;
  assign out_o.in_arm_window  = res.in_arm_window;
  assign out_o.stop_needed    = res.stop_needed;
  assign out_o.start_accepted = res.start_accepted;

endmodule

// File: hw/rtl/bts_cfg_regs.sv
module bts_cfg_regs
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_stat_t          stat_o
);

  cfg_t regs_q, regs_d;
  logic hit;
  logic ap_ok, win_ok, gap_ok;
  logic [NumSlots-1:0] slot_ok;
  logic [CfgW:0] win_sum;

  // Address decode; indexes past the last register are dropped.
  always_comb begin
    regs_d = regs_q;
    hit    = 1'b0;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegArmPeriod: begin
          regs_d.arm_period = cfg_data_i;
          hit = 1'b1;
        end
        RegArmWindow: begin
          regs_d.arm_window = cfg_data_i;
          hit = 1'b1;
        end
        RegGuardTime: begin
          regs_d.guard_time = cfg_data_i;
          hit = 1'b1;
        end
        RegMaxGap: begin
          regs_d.max_gap = cfg_data_i;
          hit = 1'b1;
        end
        RegWheelPeriod: begin
          regs_d.slot_period[0] = cfg_data_i;
          hit = 1'b1;
        end
        RegLiftPeriod: begin
          regs_d.slot_period[1] = cfg_data_i;
          hit = 1'b1;
        end
        RegStatusPeriod: begin
          regs_d.slot_period[2] = cfg_data_i;
          hit = 1'b1;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else begin
      regs_q <= regs_d;
    end
  end

  // Start validation of the current register set.
  always_comb begin
    win_sum = {1'b0, regs_q.arm_window} + {1'b0, regs_q.guard_time};
    ap_ok   = (regs_q.arm_period != '0) && (regs_q.arm_period <= MaxPeriodUs);
    win_ok  = (regs_q.arm_window != '0) && (regs_q.guard_time != '0) &&
              (win_sum < {1'b0, regs_q.arm_period});
    gap_ok  = (regs_q.max_gap != '0) && (regs_q.max_gap <= regs_q.arm_period);
    for (int i = 0; i < NumSlots; i++) begin
      slot_ok[i] = (regs_q.slot_period[i] >= regs_q.arm_period) &&
                   (regs_q.slot_period[i] <= MaxPeriodUs);
    end
  end

  assign stat_o.regs   = regs_q;
  assign stat_o.cfg_ok = ap_ok && win_ok && gap_ok && (&slot_ok);
  assign stat_o.disarm = hit;

endmodule

// File: hw/rtl/bts_in_stage.sv
module bts_in_stage
  import bts_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  adv_i,
  output logic  vld_o,
  output item_t item_o
);

  logic  vld_q;
  item_t item_q;
  logic  take;

  // The register frees up in the same cycle the engine consumes it.
  assign in_ready_o = !vld_q || adv_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// File: hw/rtl/bts_engine.sv
module bts_engine
  import bts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_stat_t cfg_i,
  input  logic      vld_i,
  input  item_t     item_i,
  output logic      adv_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_t      res_o
);

  logic [TimeW-1:0]              last_time_q, last_time_d;
  logic [CfgW-1:0]               phase_q, phase_d;
  logic [NumSlots-1:0][CfgW-1:0] cd_q, cd_d;
  logic                          armed_q, armed_d;
  logic                          fault_q, fault_d;
  logic                          out_vld_q;
  res_t                          res_q, res_d;

  logic                          fire;
  logic [TimeW-1:0]              elapsed;
  logic [CfgW-1:0]               el20;
  logic                          gap_bad;
  logic [CfgW:0]                 sum, sum_adj;
  logic [CfgW-1:0]               phase_new;
  logic [NumSlots-1:0][CfgW-1:0] cd_dec;
  logic [CfgW-1:0]               to_arm;

  // The result register advances when empty or when its item is taken.
  assign adv_o = !out_vld_q || out_ready_i;
  assign fire  = vld_i && adv_o;

  // Poll datapath: elapsed time, phase wrap and slot countdowns.
  always_comb begin
    elapsed   = item_i.time_us - last_time_q;
    el20      = elapsed[CfgW-1:0];
    gap_bad   = elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.regs.max_gap};
    sum       = {1'b0, phase_q} + {1'b0, el20};
    sum_adj   = (sum >= {1'b0, cfg_i.regs.arm_period}) ?
                sum - {1'b0, cfg_i.regs.arm_period} : sum;
    phase_new = sum_adj[CfgW-1:0];
    to_arm    = cfg_i.regs.arm_period - phase_new;
    for (int i = 0; i < NumSlots; i++) begin
      cd_dec[i] = ({{(TimeW-CfgW){1'b0}}, cd_q[i]} <= elapsed) ? '0 : cd_q[i] - el20;
    end
  end

  // Item handling and next state.
  always_comb begin
    last_time_d = last_time_q;
    phase_d     = phase_q;
    cd_d        = cd_q;
    armed_d     = armed_q;
    fault_d     = fault_q;
    res_d       = '0;
    if (fire) begin
      if (item_i.opcode == OpStart) begin
        last_time_d = '0;
        phase_d     = '0;
        cd_d        = '0;
        armed_d     = 1'b0;
        fault_d     = 1'b0;
        if (cfg_i.cfg_ok) begin
          last_time_d          = item_i.time_us;
          armed_d              = 1'b1;
          res_d.start_accepted = 1'b1;
        end else begin
          res_d.stop_needed = 1'b1;
        end
      end else if (!armed_q || fault_q) begin
        res_d.stop_needed = 1'b1;
      end else if (gap_bad) begin
        fault_d           = 1'b1;
        res_d.stop_needed = 1'b1;
      end else begin
        last_time_d = item_i.time_us;
        phase_d     = phase_new;
        cd_d        = cd_dec;
        if (phase_new < cfg_i.regs.arm_window) begin
          res_d.in_arm_window = 1'b1;
        end else if ((cfg_i.regs.arm_period > phase_new) &&
                     (to_arm > cfg_i.regs.guard_time)) begin
          res_d.free_time = to_arm - cfg_i.regs.guard_time;
          for (int i = 0; i < NumSlots; i++) begin
            if (cd_dec[i] == '0) begin
              res_d.due_mask[i] = 1'b1;
              cd_d[i]           = cfg_i.regs.slot_period[i];
            end
          end
        end
      end
    end
    // A write to an existing register always drops the armed state.
    if (cfg_i.disarm) begin
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      phase_q     <= '0;
      cd_q        <= '0;
      armed_q     <= 1'b0;
      fault_q     <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      last_time_q <= last_time_d;
      phase_q     <= phase_d;
      cd_q        <= cd_d;
      armed_q     <= armed_d;
      fault_q     <= fault_d;
      if (adv_o) begin
        out_vld_q <= vld_i;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule
